FILE: hw/rtl/dep_pkg.sv
package dep_pkg;

  // Default sizes and reset values.
  localparam int POP_SIZE_DEF = 128;
  localparam int DIMS_DEF     = 32;
  localparam logic [15:0] DIFF_WEIGHT_RST = 16'd8192;
  localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
  localparam logic signed [32:0] ONE_Q20 = 33'sd1048576;

  // Operation codes.
  localparam logic [2:0] OP_LDM   = 3'd0;
  localparam logic [2:0] OP_LDB   = 3'd1;
  localparam logic [2:0] OP_TRIAL = 3'd2;
  localparam logic [2:0] OP_SEL   = 3'd3;
  localparam logic [2:0] OP_RDB   = 3'd4;

  // Population read address selects.
  localparam logic [1:0] SEL_A = 2'd0;
  localparam logic [1:0] SEL_B = 2'd1;
  localparam logic [1:0] SEL_C = 2'd2;
  localparam logic [1:0] SEL_M = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       accept;
    logic       pop_ld_wr;
    logic       best_ld_wr;
    logic       best_rd_dim;
    logic       elem_cap;
    logic [1:0] pop_sel;
    logic       cap_a;
    logic       cap_b;
    logic       cap_c;
    logic       cap_m;
    logic       mul_en;
    logic       tr_wr;
    logic       fit_rd;
    logic       fit_best;
    logic       score_ld;
    logic       decide;
    logic       cp_rd;
  } dep_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic ok;
    logic repl;
  } dep_stat_t;

endpackage

FILE: hw/rtl/differential_evolution_step.sv
// Channel  Handshake            Ports
// input    start high, busy low in_op, in_member, in_dim, in_value, in_donor_*, ...
// result   out_valid, one cycle out_element_value, out_member_fitness, ...
// config   cfg_we               cfg_wdata (differential weight, Q2.14)
//
// A best load also recomputes the best fitness from the best vector.
// A trial build goes through one population read port that serves four reads per dimension.
// A select copies the trial back into the member only when the trial replaces it.
// Reset is synchronous and active low; stores hold nothing defined until written.
// The receiver cannot stall; busy stays high until the result cycle ends.
module differential_evolution_step #(
  parameter int POP_SIZE = dep_pkg::POP_SIZE_DEF,
  parameter int DIMS     = dep_pkg::DIMS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_op,
  input  logic [6:0]         in_member,
  input  logic [4:0]         in_dim,
  input  logic signed [31:0] in_value,
  input  logic [6:0]         in_donor_a,
  input  logic [6:0]         in_donor_b,
  input  logic [6:0]         in_donor_c,
  input  logic [4:0]         in_forced_dim,
  input  logic [31:0]        in_cross_mask,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  output logic               out_valid,
  output logic signed [31:0] out_element_value,
  output logic [47:0]        out_member_fitness,
  output logic               out_replaced,
  output logic               out_new_best,
  output logic [47:0]        out_best_fitness
);

  localparam int CW = $clog2(DIMS + 3);

  dep_pkg::dep_cmd_t  cmd;
  dep_pkg::dep_stat_t stat;
  logic [CW-1:0]      cnt;

  // Operation sequencer.
  dep_ctrl #(.DIMS(DIMS), .CW(CW)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_op     (in_op),
    .stat      (stat),
    .cmd       (cmd),
    .cnt       (cnt),
    .out_valid (out_valid)
  );

  // Stores and arithmetic.
  dep_dp #(.POP_SIZE(POP_SIZE), .DIMS(DIMS), .CW(CW)) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_op              (in_op),
    .in_member          (in_member),
    .in_dim             (in_dim),
    .in_value           (in_value),
    .in_donor_a         (in_donor_a),
    .in_donor_b         (in_donor_b),
    .in_donor_c         (in_donor_c),
    .in_forced_dim      (in_forced_dim),
    .in_cross_mask      (in_cross_mask),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .cmd                (cmd),
    .cnt                (cnt),
    .stat               (stat),
    .out_element_value  (out_element_value),
    .out_member_fitness (out_member_fitness),
    .out_replaced       (out_replaced),
    .out_new_best       (out_new_best),
    .out_best_fitness   (out_best_fitness)
  );

endmodule

FILE: hw/rtl/dep_ctrl.sv
module dep_ctrl #(
  parameter int DIMS = dep_pkg::DIMS_DEF,
  parameter int CW   = $clog2(DIMS + 3)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        in_op,
  input  dep_pkg::dep_stat_t stat,
  output dep_pkg::dep_cmd_t  cmd,
  output logic [CW-1:0]     cnt,
  output logic              out_valid
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_FIT   = 3'd2;
  localparam logic [2:0] S_COPY  = 3'd3;
  localparam logic [2:0] S_TRIAL = 3'd4;
  localparam logic [2:0] S_RDW   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  localparam logic [CW-1:0] LAST_DIM = CW'(DIMS - 1);
  localparam logic [CW-1:0] N_DIMS   = CW'(DIMS);
  localparam logic [CW-1:0] FIT_END  = CW'(DIMS + 2);

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [2:0]    ph_r, ph_nxt;
  logic [2:0]    op_r, op_nxt;
  logic          ok_r, ok_nxt;

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);
  assign cnt       = cnt_r;

  // Sequencing of each operation.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ph_nxt    = ph_r;
    op_nxt    = op_r;
    ok_nxt    = ok_r;
    cmd       = '0;
    cmd.pop_sel  = dep_pkg::SEL_M;
    cmd.fit_best = (op_r == dep_pkg::OP_LDB);
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          op_nxt     = in_op;
          ok_nxt     = stat.ok;
          cnt_nxt    = '0;
          ph_nxt     = '0;
          state_nxt  = S_LOAD;
        end
      end
      S_LOAD: begin
        state_nxt = S_DONE;
        case (op_r)
          dep_pkg::OP_LDM: cmd.pop_ld_wr = ok_r;
          dep_pkg::OP_LDB: begin
            cmd.best_ld_wr = ok_r;
            if (ok_r) state_nxt = S_FIT;
          end
          dep_pkg::OP_TRIAL: if (ok_r) state_nxt = S_TRIAL;
          dep_pkg::OP_SEL:   if (ok_r) state_nxt = S_FIT;
          dep_pkg::OP_RDB: begin
            cmd.best_rd_dim = 1'b1;
            state_nxt       = S_RDW;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_FIT: begin
        cmd.fit_rd = (cnt_r < N_DIMS);
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == FIT_END) begin
          cnt_nxt = '0;
          if (op_r == dep_pkg::OP_LDB) begin
            cmd.score_ld = 1'b1;
            state_nxt    = S_DONE;
          end else begin
            cmd.decide = 1'b1;
            state_nxt  = stat.repl ? S_COPY : S_DONE;
          end
        end
      end
      S_COPY: begin
        cmd.cp_rd = (cnt_r < N_DIMS);
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == N_DIMS) state_nxt = S_DONE;
      end
      S_TRIAL: begin
        ph_nxt = ph_r + 1'b1;
        case (ph_r)
          3'd0: cmd.pop_sel = dep_pkg::SEL_A;
          3'd1: begin
            cmd.pop_sel = dep_pkg::SEL_B;
            cmd.cap_a   = 1'b1;
          end
          3'd2: begin
            cmd.pop_sel = dep_pkg::SEL_C;
            cmd.cap_b   = 1'b1;
          end
          3'd3: cmd.cap_c = 1'b1;
          3'd4: begin
            cmd.cap_m  = 1'b1;
            cmd.mul_en = 1'b1;
          end
          default: begin
            cmd.tr_wr = 1'b1;
            ph_nxt    = '0;
            cnt_nxt   = cnt_r + 1'b1;
            if (cnt_r == LAST_DIM) state_nxt = S_DONE;
          end
        endcase
      end
      S_RDW: begin
        cmd.elem_cap = ok_r;
        state_nxt    = S_DONE;
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ph_r    <= '0;
      op_r    <= '0;
      ok_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ph_r    <= ph_nxt;
      op_r    <= op_nxt;
      ok_r    <= ok_nxt;
    end
  end

`ifndef SYNTHESIS
  // An accepted item always makes the block busy.
  assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
    else $error("accepted item did not start work");
  // A result is shown for one cycle only.
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");
  // Trial writes only happen for the trial operation.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tr_wr |-> (op_r == dep_pkg::OP_TRIAL && ok_r))
    else $error("trial write outside trial build");
  // The copy follows only a replacing decision.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIT && state_nxt == S_COPY) |-> stat.repl)
    else $error("copy without replacement");
`endif

endmodule

FILE: hw/rtl/dep_dp.sv
module dep_dp #(
  parameter int POP_SIZE = dep_pkg::POP_SIZE_DEF,
  parameter int DIMS     = dep_pkg::DIMS_DEF,
  parameter int CW       = $clog2(DIMS + 3)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [2:0]         in_op,
  input  logic [6:0]         in_member,
  input  logic [4:0]         in_dim,
  input  logic signed [31:0] in_value,
  input  logic [6:0]         in_donor_a,
  input  logic [6:0]         in_donor_b,
  input  logic [6:0]         in_donor_c,
  input  logic [4:0]         in_forced_dim,
  input  logic [31:0]        in_cross_mask,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  input  dep_pkg::dep_cmd_t  cmd,
  input  logic [CW-1:0]      cnt,
  output dep_pkg::dep_stat_t stat,
  output logic signed [31:0] out_element_value,
  output logic [47:0]        out_member_fitness,
  output logic               out_replaced,
  output logic               out_new_best,
  output logic [47:0]        out_best_fitness
);

  localparam int DEPTH = POP_SIZE * DIMS;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = $clog2(DIMS);

  // Stores.
  logic [31:0] pop_mem  [DEPTH];
  logic [31:0] tr_mem   [DEPTH];
  logic [31:0] best_mem [DIMS];

  logic [31:0] pop_rd_r, tr_rd_r, best_rd_r;

  // Latched item fields and configuration.
  logic [6:0]  member_r, da_r, db_r, dc_r;
  logic [4:0]  dim_r, forced_r;
  logic [31:0] value_r, mask_r;
  logic [15:0] fw_r;

  logic          arg_ok;
  logic [IW-1:0] idx;
  logic [6:0]    idx7;
  logic [AW-1:0] mbase, pop_raddr, pop_waddr;
  logic [6:0]    sel_m;
  logic [IW-1:0] best_raddr, best_waddr;
  logic [31:0]   best_wdata;
  logic          pop_we, best_we;

  // Trial datapath.
  logic signed [31:0] a_r, b_r, c_r;
  logic [31:0]        m_r;
  logic signed [32:0] diff;
  logic signed [49:0] p_r, p_rnd;
  logic signed [35:0] s_val;
  logic signed [36:0] r_sum;
  logic [31:0]        mut;
  logic               take;

  // Fitness lanes.
  logic               v1_r, v2_r, cp_v_r;
  logic [IW-1:0]      cp_idx_r;
  logic signed [32:0] dx, dt;
  logic [31:0]        mx, mt;
  logic [63:0]        sqx_r, sqt_r;
  logic [47:0]        accx_r, acct_r;
  logic [47:0]        accx_nxt, acct_nxt;
  logic [31:0]        lane_x;

  // Results.
  logic [31:0] elem_r;
  logic [47:0] fit_r, score_r;
  logic        repl_r, nb_r;

  function automatic logic [47:0] acc_add(input logic [47:0] acc, input logic [63:0] sq);
    logic [63:0] rnd;
    logic [48:0] sum;
    rnd = sq + 64'd524288;
    sum = {1'b0, acc} + 49'(rnd[63:20]);
    return sum[48] ? dep_pkg::MAX48 : sum[47:0];
  endfunction

  // Argument range checks on the incoming item.
  always_comb begin
    case (in_op)
      dep_pkg::OP_LDM:   arg_ok = (int'(in_member) < POP_SIZE) && (int'(in_dim) < DIMS);
      dep_pkg::OP_LDB:   arg_ok = (int'(in_dim) < DIMS);
      dep_pkg::OP_TRIAL: arg_ok = (int'(in_member) < POP_SIZE) &&
                                  (int'(in_donor_a) < POP_SIZE) &&
                                  (int'(in_donor_b) < POP_SIZE) &&
                                  (int'(in_donor_c) < POP_SIZE);
      dep_pkg::OP_SEL:   arg_ok = (int'(in_member) < POP_SIZE);
      dep_pkg::OP_RDB:   arg_ok = (int'(in_dim) < DIMS);
      default:           arg_ok = 1'b0;
    endcase
  end
  assign stat = '{ok: arg_ok, repl: (acct_r < accx_r)};

  // Addressing.
  assign idx   = cnt[IW-1:0];
  assign idx7  = 7'(idx);
  assign mbase = AW'(member_r) * AW'(DIMS);
  always_comb begin
    case (cmd.pop_sel)
      dep_pkg::SEL_A: sel_m = da_r;
      dep_pkg::SEL_B: sel_m = db_r;
      dep_pkg::SEL_C: sel_m = dc_r;
      default:        sel_m = member_r;
    endcase
  end
  assign pop_raddr  = AW'(sel_m) * AW'(DIMS) + AW'(idx);
  assign pop_we     = cmd.pop_ld_wr || cp_v_r;
  assign pop_waddr  = mbase + (cp_v_r ? AW'(cp_idx_r) : AW'(dim_r));
  assign best_raddr = cmd.best_rd_dim ? IW'(dim_r) : idx;
  assign best_we    = cmd.best_ld_wr || (cp_v_r && nb_r);
  assign best_waddr = cp_v_r ? cp_idx_r : IW'(dim_r);
  assign best_wdata = cp_v_r ? tr_rd_r : value_r;

  // Population memory.
  always_ff @(posedge clk) begin
    if (pop_we) pop_mem[pop_waddr] <= cp_v_r ? tr_rd_r : value_r;
    pop_rd_r <= pop_mem[pop_raddr];
  end

  // Trial memory.
  always_ff @(posedge clk) begin
    if (cmd.tr_wr) tr_mem[mbase + AW'(idx)] <= take ? mut : m_r;
    tr_rd_r <= tr_mem[mbase + AW'(idx)];
  end

  // Best vector memory.
  always_ff @(posedge clk) begin
    if (best_we) best_mem[best_waddr] <= best_wdata;
    best_rd_r <= best_mem[best_raddr];
  end

  // Mutant value a + F*(b - c), rounded and saturated.
  assign diff  = {b_r[31], b_r} - {c_r[31], c_r};
  assign p_rnd = p_r + 50'sd8192;
  assign s_val = p_rnd[49:14];
  assign r_sum = {{5{a_r[31]}}, a_r} + {s_val[35], s_val};
  always_comb begin
    if (r_sum[36:31] == 6'b000000 || r_sum[36:31] == 6'b111111) mut = r_sum[31:0];
    else if (r_sum[36]) mut = 32'h8000_0000;
    else mut = 32'h7FFF_FFFF;
  end
  assign take = (idx7 == 7'(forced_r) && int'(forced_r) < DIMS) ||
                (idx7 < 7'd32 && mask_r[idx7[4:0]]);

  // Squared distance from one, per lane.
  assign lane_x = cmd.fit_best ? best_rd_r : pop_rd_r;
  assign dx = {lane_x[31], lane_x} - dep_pkg::ONE_Q20;
  assign dt = {tr_rd_r[31], tr_rd_r} - dep_pkg::ONE_Q20;
  assign mx = dx[32] ? 32'(-dx) : dx[31:0];
  assign mt = dt[32] ? 32'(-dt) : dt[31:0];
  assign accx_nxt = acc_add(accx_r, sqx_r);
  assign acct_nxt = acc_add(acct_r, sqt_r);

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      member_r <= in_member;
      dim_r    <= in_dim;
      value_r  <= in_value;
      da_r     <= in_donor_a;
      db_r     <= in_donor_b;
      dc_r     <= in_donor_c;
      forced_r <= in_forced_dim;
      mask_r   <= in_cross_mask;
    end
    if (cmd.cap_a) a_r <= pop_rd_r;
    if (cmd.cap_b) b_r <= pop_rd_r;
    if (cmd.cap_c) c_r <= pop_rd_r;
    if (cmd.cap_m) m_r <= pop_rd_r;
    if (cmd.mul_en) p_r <= $signed({1'b0, fw_r}) * diff;
    if (v1_r) begin
      sqx_r <= mx * mx;
      sqt_r <= mt * mt;
    end
    cp_idx_r <= idx;
  end

  // Control, accumulators and results.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r    <= dep_pkg::DIFF_WEIGHT_RST;
      score_r <= dep_pkg::MAX48;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      cp_v_r  <= 1'b0;
      accx_r  <= '0;
      acct_r  <= '0;
      elem_r  <= '0;
      fit_r   <= '0;
      repl_r  <= 1'b0;
      nb_r    <= 1'b0;
    end else begin
      if (cfg_we) fw_r <= cfg_wdata;
      v1_r   <= cmd.fit_rd;
      v2_r   <= v1_r;
      cp_v_r <= cmd.cp_rd;
      if (cmd.accept) begin
        accx_r <= '0;
        acct_r <= '0;
        elem_r <= '0;
        fit_r  <= '0;
        repl_r <= 1'b0;
        nb_r   <= 1'b0;
      end else if (v2_r) begin
        accx_r <= accx_nxt;
        acct_r <= acct_nxt;
      end
      if (cmd.elem_cap) elem_r <= best_rd_r;
      if (cmd.score_ld) score_r <= accx_r;
      if (cmd.decide) begin
        fit_r  <= stat.repl ? acct_r : accx_r;
        repl_r <= stat.repl;
        nb_r   <= stat.repl && (acct_r < score_r);
        if (stat.repl && (acct_r < score_r)) score_r <= acct_r;
      end
    end
  end

  assign out_element_value  = elem_r;
  assign out_member_fitness = fit_r;
  assign out_replaced       = repl_r;
  assign out_new_best       = nb_r;
  assign out_best_fitness   = score_r;

endmodule

FILE: dv/dep_checker.sv
`timescale 1ns / 1ps

// Watches the item and result channels of the differential evolution step
// block, keeps its own copy of the block's stores, predicts every result
// and compares it with what the block returns.
module dep_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [2:0]         in_op,
  input  logic [6:0]         in_member,
  input  logic [4:0]         in_dim,
  input  logic signed [31:0] in_value,
  input  logic [6:0]         in_donor_a,
  input  logic [6:0]         in_donor_b,
  input  logic [6:0]         in_donor_c,
  input  logic [4:0]         in_forced_dim,
  input  logic [31:0]        in_cross_mask,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  input  logic               out_valid,
  input  logic signed [31:0] out_element_value,
  input  logic [47:0]        out_member_fitness,
  input  logic               out_replaced,
  input  logic               out_new_best,
  input  logic [47:0]        out_best_fitness,
  output int                 fail_count,
  output int                 outstanding
);

  localparam int NPOP = dep_pkg::POP_SIZE_DEF;
  localparam int NDIM = dep_pkg::DIMS_DEF;

  typedef struct packed {
    logic [31:0] element_value;
    logic [47:0] member_fitness;
    logic        replaced;
    logic        new_best;
    logic [47:0] best_fitness;
  } dep_result_t;

  logic [31:0] pop_mem [NPOP*NDIM];
  logic [31:0] trial_mem [NPOP*NDIM];
  logic [31:0] best_vec [NDIM];
  logic [47:0] best_score;
  logic [15:0] weight;
  dep_result_t pending_results [$];

  // Sphere fitness: sum of (x - 1.0)^2 with each term rounded to Q.20.
  function automatic logic [47:0] sphere_fitness(input logic [31:0] vec [NDIM]);
    logic signed [63:0] d;
    logic [63:0] m;
    logic [63:0] acc;
    acc = 0;
    for (int i = 0; i < NDIM; i++) begin
      d = $signed(vec[i]) - 64'sd1048576;
      m = (d < 0) ? -d : d;
      acc = acc + ((m * m + (64'd1 << 19)) >> 20);
      if (acc > {16'd0, dep_pkg::MAX48}) acc = {16'd0, dep_pkg::MAX48};
    end
    return acc[47:0];
  endfunction

  // Mutant element a + F*(b - c), rounded half up and saturated to 32 bits.
  function automatic logic [31:0] mutant_elem(input logic signed [31:0] a,
                                              input logic signed [31:0] b,
                                              input logic signed [31:0] c,
                                              input logic [15:0] w);
    logic signed [63:0] ae, be, ce, p, s, r;
    ae = a;
    be = b;
    ce = c;
    p = $signed({48'd0, w}) * (be - ce);
    s = (p + 64'sd8192) >>> 14;
    r = ae + s;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  always @(posedge clk) begin
    dep_result_t want, got;
    logic [31:0] cur_vec [NDIM];
    logic [31:0] trial_vec [NDIM];
    logic [47:0] fo, fn;
    int base;
    if (!rst_n) begin
      weight = dep_pkg::DIFF_WEIGHT_RST;
      best_score = dep_pkg::MAX48;
      pending_results.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) weight = cfg_wdata;

      // Compare each returned item with the oldest prediction.
      if (out_valid) begin
        got = '{out_element_value, out_member_fitness, out_replaced,
                out_new_best, out_best_fitness};
        if (pending_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("ERROR: result with no item pending");
        end else begin
          want = pending_results.pop_front();
          if (got != want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("ERROR: elem %h/%h fit %h/%h repl %b/%b nb %b/%b best %h/%h (exp/act)",
                       want.element_value, got.element_value,
                       want.member_fitness, got.member_fitness,
                       want.replaced, got.replaced, want.new_best, got.new_best,
                       want.best_fitness, got.best_fitness);
          end
        end
      end

      // Predict the result of each accepted item.
      if (start && !busy) begin
        want = '0;
        base = in_member * NDIM;
        case (in_op)
          dep_pkg::OP_LDM: pop_mem[base + in_dim] = in_value;
          dep_pkg::OP_LDB: begin
            best_vec[in_dim] = in_value;
            best_score = sphere_fitness(best_vec);
          end
          dep_pkg::OP_TRIAL: begin
            for (int i = 0; i < NDIM; i++) begin
              if (in_cross_mask[i] || i == in_forced_dim)
                trial_mem[base + i] = mutant_elem(pop_mem[in_donor_a*NDIM + i],
                                                  pop_mem[in_donor_b*NDIM + i],
                                                  pop_mem[in_donor_c*NDIM + i], weight);
              else
                trial_mem[base + i] = pop_mem[base + i];
            end
          end
          dep_pkg::OP_SEL: begin
            for (int i = 0; i < NDIM; i++) begin
              cur_vec[i] = pop_mem[base + i];
              trial_vec[i] = trial_mem[base + i];
            end
            fo = sphere_fitness(cur_vec);
            fn = sphere_fitness(trial_vec);
            want.member_fitness = fo;
            if (fn < fo) begin
              for (int i = 0; i < NDIM; i++) pop_mem[base + i] = trial_vec[i];
              want.member_fitness = fn;
              want.replaced = 1'b1;
              if (fn < best_score) begin
                for (int i = 0; i < NDIM; i++) best_vec[i] = trial_vec[i];
                best_score = fn;
                want.new_best = 1'b1;
              end
            end
          end
          dep_pkg::OP_RDB: want.element_value = best_vec[in_dim];
          default: ;
        endcase
        want.best_fitness = best_score;
        pending_results.push_back(want);
      end
    end
    outstanding = pending_results.size();
  end

endmodule

FILE: dv/differential_evolution_step_tb.sv
`timescale 1ns / 1ps

module differential_evolution_step_tb;

  localparam int NPOP = dep_pkg::POP_SIZE_DEF;
  localparam int NDIM = dep_pkg::DIMS_DEF;
  localparam int NFILL = 16;
  localparam int NLOW = 12;
  localparam int RAND_ITEMS = 1420;
  localparam int STALL_LIMIT = 4000;
  localparam logic [2:0] OP_SPARE5 = 3'd5;
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] in_op = '0;
  logic [6:0] in_member = '0;
  logic [4:0] in_dim = '0;
  logic signed [31:0] in_value = '0;
  logic [6:0] in_donor_a = '0;
  logic [6:0] in_donor_b = '0;
  logic [6:0] in_donor_c = '0;
  logic [4:0] in_forced_dim = '0;
  logic [31:0] in_cross_mask = '0;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic out_valid;
  logic signed [31:0] out_element_value;
  logic [47:0] out_member_fitness;
  logic out_replaced;
  logic out_new_best;
  logic [47:0] out_best_fitness;
  int fail_count;
  int outstanding;

  logic trial_built [NPOP];
  bit idle_on;
  int items_sent;
  int stall_cycles;

  always #2 clk = ~clk;

  differential_evolution_step dut (
    .clk, .rst_n, .start, .busy, .in_op, .in_member, .in_dim, .in_value,
    .in_donor_a, .in_donor_b, .in_donor_c, .in_forced_dim, .in_cross_mask,
    .cfg_we, .cfg_wdata, .out_valid, .out_element_value, .out_member_fitness,
    .out_replaced, .out_new_best, .out_best_fitness
  );

  dep_checker u_chk (
    .clk, .rst_n, .start, .busy, .in_op, .in_member, .in_dim, .in_value,
    .in_donor_a, .in_donor_b, .in_donor_c, .in_forced_dim, .in_cross_mask,
    .cfg_we, .cfg_wdata, .out_valid, .out_element_value, .out_member_fitness,
    .out_replaced, .out_new_best, .out_best_fitness, .fail_count, .outstanding
  );

  // Watchdog: ends the run when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Element values: mostly near the optimum, some full range and extremes.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0, 1: return $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
      2: return 32'h0010_0000 + $urandom_range(0, 32'h1000) - 32'h800;
      3: return $urandom();
      4: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
    endcase
  endfunction

  // Members that are fully loaded: the low ones and the top few.
  function automatic logic [6:0] fill_member(input int k);
    return 7'((k < NLOW) ? k : k + NPOP - NFILL);
  endfunction

  function automatic logic [6:0] any_member();
    return fill_member($urandom_range(0, NFILL - 1));
  endfunction

  function automatic logic [6:0] r7();
    return 7'($urandom());
  endfunction

  function automatic logic [4:0] r5();
    return 5'($urandom());
  endfunction

  // Sends one item and returns at the edge where it is accepted.
  task automatic send_item(input logic [2:0] op, input logic [6:0] member,
                           input logic [4:0] dim, input logic [31:0] value,
                           input logic [6:0] da, input logic [6:0] db,
                           input logic [6:0] dc, input logic [4:0] forced,
                           input logic [31:0] mask);
    logic busy_seen;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    start <= 1'b1;
    in_op <= op;
    in_member <= member;
    in_dim <= dim;
    in_value <= value;
    in_donor_a <= da;
    in_donor_b <= db;
    in_donor_c <= dc;
    in_forced_dim <= forced;
    in_cross_mask <= mask;
    do begin
      @(negedge clk);
      busy_seen = busy;
      @(posedge clk);
    end while (busy_seen);
    if (op == dep_pkg::OP_TRIAL) trial_built[member] = 1'b1;
    items_sent++;
  endtask

  // Lowers start and waits until every pending result has come back.
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  task automatic write_weight(input logic [15:0] w);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // One random item; selects only name members whose trial has been built.
  task automatic random_item();
    logic [6:0] m;
    int pick;
    m = any_member();
    pick = $urandom_range(0, 99);
    if (pick < 20)
      send_item(dep_pkg::OP_LDM, m, r5(), pick_value(), r7(), r7(), r7(), r5(),
                $urandom());
    else if (pick < 28)
      send_item(dep_pkg::OP_LDB, r7(), r5(), pick_value(), r7(), r7(), r7(), r5(),
                $urandom());
    else if (pick < 50)
      send_item(dep_pkg::OP_TRIAL, m, r5(), $urandom(), any_member(), any_member(),
                any_member(), r5(), $urandom_range(0, 1) ? $urandom() : 32'h0);
    else if (pick < 80) begin
      if (!trial_built[m])
        send_item(dep_pkg::OP_TRIAL, m, r5(), $urandom(), any_member(), any_member(),
                  any_member(), r5(), $urandom());
      send_item(dep_pkg::OP_SEL, m, r5(), $urandom(), r7(), r7(), r7(), r5(),
                $urandom());
    end else if (pick < 95)
      send_item(dep_pkg::OP_RDB, r7(), r5(), $urandom(), r7(), r7(), r7(), r5(),
                $urandom());
    else
      send_item(3'($urandom_range(OP_SPARE5, OP_SPARE7)), r7(), r5(),
                $urandom(), r7(), r7(), r7(), r5(), $urandom());
  endtask

  initial begin
    logic [15:0] weights [4];
    for (int i = 0; i < NPOP; i++) trial_built[i] = 1'b0;
    items_sent = 0;
    idle_on = 1'b1;
    weights = '{16'd0, 16'hFFFF, 16'd13107, 16'($urandom())};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill the members in use; member 0 starts far from the optimum.
    for (int k = 0; k < NFILL; k++)
      for (int d = 0; d < NDIM; d++)
        send_item(dep_pkg::OP_LDM, fill_member(k), 5'(d),
                  (k == 0) ? 32'h7FFF_0000 : pick_value(), 0, 0, 0, 0, 0);

    // Copy member 1 into member 0 through a trial so the best vector is set.
    send_item(dep_pkg::OP_TRIAL, 0, 0, 0, 1, 2, 2, 0, 32'hFFFF_FFFF);
    send_item(dep_pkg::OP_SEL, 0, 0, 0, 0, 0, 0, 0, 0);

    // Directed items: extremes, every op, ties, forced dimension, spare ops.
    send_item(dep_pkg::OP_RDB, 127, 0, 0, 0, 0, 0, 0, 0);
    send_item(dep_pkg::OP_RDB, 0, 31, 0, 0, 0, 0, 0, 0);
    send_item(dep_pkg::OP_LDB, 0, 31, 32'h8000_0000, 0, 0, 0, 0, 0);
    send_item(dep_pkg::OP_LDB, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 0, 0);
    send_item(dep_pkg::OP_LDB, 0, 5, 32'h0010_0000, 0, 0, 0, 0, 0);
    send_item(dep_pkg::OP_RDB, 0, 31, 0, 0, 0, 0, 0, 0);
    send_item(dep_pkg::OP_LDM, 127, 31, 32'h7FFF_FFFF, 0, 0, 0, 0, 0);
    send_item(dep_pkg::OP_LDM, 126, 31, 32'h8000_0000, 0, 0, 0, 0, 0);
    send_item(dep_pkg::OP_TRIAL, 5, 0, 0, 3, 127, 126, 31, 32'h0);
    send_item(dep_pkg::OP_SEL, 5, 0, 0, 0, 0, 0, 0, 0);
    send_item(dep_pkg::OP_TRIAL, 6, 0, 0, 6, 9, 9, 0, 32'h0);
    send_item(dep_pkg::OP_SEL, 6, 0, 0, 0, 0, 0, 0, 0);
    send_item(dep_pkg::OP_TRIAL, 127, 0, 0, 127, 126, 127, 0, 32'hFFFF_FFFF);
    send_item(dep_pkg::OP_SEL, 127, 0, 0, 0, 0, 0, 0, 0);
    send_item(OP_SPARE5, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(OP_SPARE6, 127, 31, 32'hFFFF_FFFF, 127, 127, 127, 31, 32'hFFFF_FFFF);
    send_item(OP_SPARE7, 0, 0, 0, 0, 0, 0, 0, 0);

    // Random items under several differential weights, the last part gap free.
    for (int phase = 0; phase < 4; phase++) begin
      write_weight(weights[phase]);
      for (int n = 0; n < RAND_ITEMS / 4; n++) begin
        if (phase == 3 && n > RAND_ITEMS / 8) idle_on = 1'b0;
        random_item();
      end
    end
    start <= 1'b0;

    do @(negedge clk); while (outstanding != 0);
    repeat (250) @(posedge clk);
    $display("Ran %0d items over population loads, trial builds and selects,",
             items_sent);
    $display("best loads and reads, spare ops and five differential weights.");
    if (fail_count == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/dep_pkg.sv
hw/rtl/dep_ctrl.sv
hw/rtl/dep_dp.sv
hw/rtl/differential_evolution_step.sv
dv/dep_checker.sv
dv/differential_evolution_step_tb.sv
